// File: design/bst_pkg.sv
// Shared types, constants and codes for the beacon sighting table.
`timescale 1ns / 1ps
`default_nettype none
package bst_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = IDX_W + 1;
	localparam int MAX_OUT     = 32;

	// operation kinds
	localparam logic [1:0] K_OBSERVE = 2'd0;
	localparam logic [1:0] K_COUNT   = 2'd1;
	localparam logic [1:0] K_AGE     = 2'd2;
	localparam logic [1:0] K_SORT    = 2'd3;

	// result status codes
	localparam logic [2:0] ST_UPDATED  = 3'd0;
	localparam logic [2:0] ST_ADDED    = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_FILTERED = 3'd3;
	localparam logic [2:0] ST_COUNT    = 3'd4;
	localparam logic [2:0] ST_AGED     = 3'd5;
	localparam logic [2:0] ST_ITEM     = 3'd6;
	localparam logic [2:0] ST_NONE     = 3'd7;

	// configuration register indexes
	localparam logic [1:0] REG_MAJOR_LOW  = 2'd0;
	localparam logic [1:0] REG_MAJOR_HIGH = 2'd1;
	localparam logic [1:0] REG_TABLE_SIZE = 2'd2;

	typedef struct packed {
		logic [1:0]        kind;
		logic [31:0]       now_secs;
		logic [15:0]       major;
		logic [15:0]       minor;
		logic signed [7:0] rssi;
		logic [7:0]        extra;
		logic [31:0]       window_secs;
		logic [5:0]        max_count;
	} req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [4:0]        slot;
		logic [5:0]        count;
		logic [15:0]       out_major;
		logic [15:0]       out_minor;
		logic signed [7:0] out_rssi;
		logic [7:0]        out_extra;
		logic              last;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture request, clear working state
		logic scan;       // process current entry for the operation
		logic fill;       // observe end: write free entry if any
		logic next_level; // sort: adopt best level, restart index
		logic rewind;     // sort: restart index for a new level search
		logic skip;       // sort emit: advance index only
		logic take;       // sort emit: capture entry as pending word
		logic push_res;   // send the single summary word
		logic push_pend;  // send pending word as the final one
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic filtered;
		logic scan_end;
		logic obs_hit;
		logic best_valid;
		logic sort_hit;
		logic k_full;
		logic k_last;
		logic pend_valid;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// File: design/bst_ctrl.sv
// Controller state machine for the beacon sighting table.
`timescale 1ns / 1ps
`default_nettype none
module bst_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  wire logic [1:0]    kind,
	input  wire bst_pkg::sts_t sts,
	output bst_pkg::cmd_t      cmd,
	output logic               req_ready
);
	import bst_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_FIN   = 3'd2;
	localparam logic [2:0] S_FIND  = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;
	localparam logic [2:0] S_FLUSH = 3'd5;

	logic [2:0] state_q, state_nxt;

	assign req_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = (kind == K_SORT) ? S_FIND : S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.filtered) begin
					state_nxt = S_FIN;
				end else if (sts.scan_end) begin
					cmd.fill  = 1'b1;
					state_nxt = S_FIN;
				end else begin
					cmd.scan = 1'b1;
					if (sts.obs_hit) state_nxt = S_FIN;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.push_res = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			S_FIND: begin
				if (sts.k_full) begin
					state_nxt = S_FLUSH;
				end else if (sts.scan_end) begin
					if (sts.best_valid) begin
						cmd.next_level = 1'b1;
						state_nxt      = S_EMIT;
					end else begin
						state_nxt = S_FLUSH;
					end
				end else begin
					cmd.scan = 1'b1;
				end
			end
			S_EMIT: begin
				if (sts.scan_end) begin
					cmd.rewind = 1'b1;
					state_nxt  = S_FIND;
				end else if (sts.sort_hit) begin
					if (!sts.pend_valid || sts.out_free) begin
						cmd.take = 1'b1;
						if (sts.k_last) state_nxt = S_FLUSH;
					end
				end else begin
					cmd.skip = 1'b1;
				end
			end
			S_FLUSH: begin
				if (sts.out_free) begin
					if (sts.pend_valid) cmd.push_pend = 1'b1;
					else                cmd.push_res  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// new work only starts from idle
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == S_IDLE) else $error("load outside idle");
	// one word pushed per cycle at most
	a_one_push: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push_res && cmd.push_pend)) else $error("double push");
	// a finished operation returns to idle
	a_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_res || cmd.push_pend) |=> state_q == S_IDLE)
		else $error("push without return to idle");

endmodule
`default_nettype wire

// File: design/bst_dp.sv
// Datapath: configuration, entry table, scan index, accumulators and output word.
`timescale 1ns / 1ps
`default_nettype none
module bst_dp (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [15:0]   cfg_data,
	input  wire bst_pkg::req_t req,
	input  wire bst_pkg::cmd_t cmd,
	output bst_pkg::sts_t      sts,
	input  wire logic          rsp_ready,
	output logic               rsp_valid,
	output bst_pkg::rsp_t      rsp
);
	import bst_pkg::*;

	logic [15:0]       major_low_q, major_high_q;
	logic [5:0]        table_size_q;
	req_t              item_q;
	logic [CNT_W-1:0]  idx_q;
	logic [15:0]       ent_major_q [TABLE_DEPTH];
	logic [15:0]       ent_minor_q [TABLE_DEPTH];
	logic signed [7:0] ent_str_q   [TABLE_DEPTH];
	logic [7:0]        ent_extra_q [TABLE_DEPTH];
	logic [31:0]       seen_q      [TABLE_DEPTH];
	logic              have_free_q, hit_q;
	logic [IDX_W-1:0]  free_slot_q, hit_slot_q;
	logic [CNT_W-1:0]  cnt_q, k_q;
	logic signed [7:0] cur_lvl_q, best_q;
	logic              best_valid_q, pend_valid_q;
	rsp_t              pend_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic [IDX_W-1:0]  ri;
	logic [CNT_W-1:0]  n_eff, limit;
	logic              occ, id_match, win_zero, cnt_hit, age_hit, best_hit;
	logic [31:0]       age;
	logic              is_obs, obs_hit, obs_wr, age_clr, push_any;
	logic [IDX_W-1:0]  wr_slot;
	rsp_t              res_word, pend_word, take_word;

	// current entry and per-entry tests
	assign ri       = idx_q[IDX_W-1:0];
	assign n_eff    = (table_size_q > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : table_size_q;
	assign limit    = (item_q.max_count > CNT_W'(MAX_OUT)) ? CNT_W'(MAX_OUT) : item_q.max_count;
	assign occ      = (seen_q[ri] != 32'd0);
	assign id_match = (ent_major_q[ri] == item_q.major) && (ent_minor_q[ri] == item_q.minor);
	assign age      = item_q.now_secs - seen_q[ri];
	assign win_zero = (item_q.window_secs == 32'd0);
	assign cnt_hit  = occ && (win_zero || age < item_q.window_secs);
	assign age_hit  = occ && (win_zero || age > item_q.window_secs);
	assign best_hit = occ && ent_str_q[ri] < cur_lvl_q &&
		(!best_valid_q || ent_str_q[ri] > best_q);
	assign is_obs   = (item_q.kind == K_OBSERVE);
	assign obs_hit  = is_obs && occ && id_match;
	assign obs_wr   = (cmd.scan && obs_hit) || (cmd.fill && is_obs && have_free_q);
	assign wr_slot  = cmd.scan ? ri : free_slot_q;
	assign age_clr  = cmd.scan && (item_q.kind == K_AGE) && age_hit;
	assign push_any = cmd.push_res || cmd.push_pend || (cmd.take && pend_valid_q);

	// status to controller
	always_comb begin
		sts            = '0;
		sts.filtered   = is_obs && (item_q.major < major_low_q || item_q.major > major_high_q);
		sts.scan_end   = (idx_q >= n_eff);
		sts.obs_hit    = obs_hit;
		sts.best_valid = best_valid_q;
		sts.sort_hit   = occ && (ent_str_q[ri] == cur_lvl_q);
		sts.k_full     = (k_q >= limit);
		sts.k_last     = ({1'b0, k_q} + {{CNT_W{1'b0}}, 1'b1}) == {1'b0, limit};
		sts.pend_valid = pend_valid_q;
		sts.out_free   = !rsp_valid_q || rsp_ready;
	end

	// summary word
	always_comb begin
		res_word      = '0;
		res_word.last = 1'b1;
		case (item_q.kind)
			K_OBSERVE: begin
				if (sts.filtered) begin
					res_word.status = ST_FILTERED;
				end else if (hit_q) begin
					res_word.status = ST_UPDATED;
					res_word.slot   = hit_slot_q;
				end else if (have_free_q) begin
					res_word.status = ST_ADDED;
					res_word.slot   = free_slot_q;
				end else begin
					res_word.status = ST_FULL;
				end
			end
			K_COUNT: begin
				res_word.status = ST_COUNT;
				res_word.count  = cnt_q;
			end
			K_AGE:   res_word.status = ST_AGED;
			default: res_word.status = ST_NONE;
		endcase
	end

	// pending sorted word; last set only when flushed
	always_comb begin
		pend_word      = pend_q;
		pend_word.last = cmd.push_pend;
	end

	// sorted word built from the current entry
	always_comb begin
		take_word           = '0;
		take_word.status    = ST_ITEM;
		take_word.out_major = ent_major_q[ri];
		take_word.out_minor = ent_minor_q[ri];
		take_word.out_rssi  = ent_str_q[ri];
		take_word.out_extra = ent_extra_q[ri];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			major_low_q  <= '0;
			major_high_q <= '0;
			table_size_q <= '0;
			idx_q        <= '0;
			have_free_q  <= 1'b0;
			hit_q        <= 1'b0;
			cnt_q        <= '0;
			k_q          <= '0;
			cur_lvl_q    <= '0;
			best_valid_q <= 1'b0;
			pend_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
			for (int j = 0; j < TABLE_DEPTH; j++) seen_q[j] <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MAJOR_LOW:  major_low_q  <= cfg_data;
					REG_MAJOR_HIGH: major_high_q <= cfg_data;
					REG_TABLE_SIZE: table_size_q <= cfg_data[5:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				idx_q        <= '0;
				have_free_q  <= 1'b0;
				hit_q        <= 1'b0;
				cnt_q        <= '0;
				k_q          <= '0;
				cur_lvl_q    <= '0;
				best_valid_q <= 1'b0;
				pend_valid_q <= 1'b0;
			end
			if (cmd.scan) begin
				idx_q <= idx_q + 1'b1;
				case (item_q.kind)
					K_OBSERVE: begin
						if (obs_hit) hit_q <= 1'b1;
						else if (!occ && !have_free_q) have_free_q <= 1'b1;
					end
					K_COUNT: if (cnt_hit) cnt_q <= cnt_q + 1'b1;
					K_SORT:  if (best_hit) best_valid_q <= 1'b1;
					default: ;
				endcase
			end
			if (cmd.skip) idx_q <= idx_q + 1'b1;
			if (cmd.next_level) begin
				cur_lvl_q    <= best_q;
				best_valid_q <= 1'b0;
				idx_q        <= '0;
			end
			if (cmd.rewind) begin
				best_valid_q <= 1'b0;
				idx_q        <= '0;
			end
			if (cmd.take) begin
				pend_valid_q <= 1'b1;
				k_q          <= k_q + 1'b1;
				idx_q        <= idx_q + 1'b1;
			end
			if (obs_wr) seen_q[wr_slot] <= item_q.now_secs;
			if (age_clr) seen_q[ri] <= '0;
			if (push_any) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= req;
		if (cmd.scan && is_obs && !occ && !have_free_q) free_slot_q <= ri;
		if (cmd.scan && obs_hit) hit_slot_q <= ri;
		if (cmd.scan && item_q.kind == K_SORT && best_hit) best_q <= ent_str_q[ri];
		if (obs_wr) begin
			ent_major_q[wr_slot] <= item_q.major;
			ent_minor_q[wr_slot] <= item_q.minor;
			ent_str_q[wr_slot]   <= item_q.rssi;
			ent_extra_q[wr_slot] <= item_q.extra;
		end
		if (cmd.take) pend_q <= take_word;
		if (push_any) rsp_q <= cmd.push_res ? res_word : pend_word;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// a word is only loaded when the output stage can take it
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push_any |-> (!rsp_valid_q || rsp_ready)) else $error("output overrun");
	// the sorted word count never exceeds MAX_OUT
	a_k_limit: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= CNT_W'(MAX_OUT)) else $error("sorted count overflow");
	// level search only goes downward
	a_best_below: assert property (@(posedge clk) disable iff (!arst_n)
		best_valid_q |-> best_q < cur_lvl_q) else $error("level order broken");

endmodule
`default_nettype wire

// File: design/beacon_sighting_table_top.sv
// Top level of the beacon sighting table: controller plus datapath.
//
// Usage:
//   req channel (req_valid/req_ready/req) takes one operation word: observe,
//   count, age out or sorted read. rsp channel (rsp_valid/rsp_ready/rsp)
//   returns the result words; last marks the final word of an operation.
//   cfg_we/cfg_index/cfg_data write major_low, major_high and table_size; the
//   user must do so only while no operation is in flight, unchecked by the block.
// Walk: every operation walks the table one entry per cycle over the
//   n = min(table_size, 32) entries in use, though the sorted emit walk holds
//   while a word waits on a low rsp_ready. An observe stops at a matching
//   entry, and a filtered one does not walk. A sorted read spends a search
//   pass and an emit pass per strength level found, then a last search pass
//   unless the word limit ends it first, and then sends the final word.
// Throughput: one operation at a time; req_ready is high only when idle,
//   and a new word is taken while the previous result still waits in the
//   output register.
// Reset: arst_n clears configuration and marks every entry free at once.
// Stall: a low rsp_ready freezes the sorted walk at the next word to send.
`timescale 1ns / 1ps
`default_nettype none
module beacon_sighting_table_top (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [15:0]   cfg_data,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire bst_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output bst_pkg::rsp_t      rsp
);
	import bst_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing
	bst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.kind      (req.kind),
		.sts       (sts),
		.cmd       (cmd),
		.req_ready (req_ready)
	);

	// table and result path
	bst_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_ready (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

// File: tb/tb_beacon_sighting_table_top.sv
// Self-checking testbench for the beacon sighting table top level.
`timescale 1ns / 1ps
`default_nettype none
module tb_beacon_sighting_table_top;
	import bst_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_MAJOR_LOW;
	logic [15:0] cfg_data = '0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	rsp_t        rsp;

	beacon_sighting_table_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req_valid(req_valid), .req_ready(req_ready),
		.req(req), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always #2 clk = ~clk;

	// sighting table as the testbench sees it
	logic [15:0] tab_major [TABLE_DEPTH];
	logic [15:0] tab_minor [TABLE_DEPTH];
	logic [7:0]  tab_rssi  [TABLE_DEPTH];
	logic [7:0]  tab_extra [TABLE_DEPTH];
	logic [31:0] tab_seen  [TABLE_DEPTH];
	logic [15:0] lim_low, lim_high;
	logic [5:0]  size_reg;

	req_t   pending_words [$];
	rsp_t   expected_words [$];
	int     send_idle_pct, recv_idle_pct;
	int     hold_off;
	int     errors;
	longint cycles;

	task automatic report(input string msg);
		$display("MISMATCH: %s", msg);
		errors++;
	endtask

	function automatic rsp_t blank(input logic [2:0] st);
		rsp_t r;
		r = '0;
		r.status = st;
		r.last = 1'b1;
		return r;
	endfunction

	// compute the result words of one operation and update the table copy
	task automatic predict_table_op(input req_t w);
		int   n, k, lim, lvl, cnt, free_at;
		rsp_t r;
		n = (size_reg > TABLE_DEPTH) ? TABLE_DEPTH : size_reg;
		case (w.kind)
			K_OBSERVE: begin
				if (w.major < lim_low || w.major > lim_high) begin
					expected_words.push_back(blank(ST_FILTERED));
					return;
				end
				free_at = -1;
				for (int i = 0; i < n; i++) begin
					if (tab_seen[i] != 0) begin
						if (tab_major[i] == w.major && tab_minor[i] == w.minor) begin
							tab_rssi[i] = w.rssi;
							tab_extra[i] = w.extra;
							tab_seen[i] = w.now_secs;
							r = blank(ST_UPDATED);
							r.slot = 5'(i);
							expected_words.push_back(r);
							return;
						end
					end else if (free_at < 0) begin
						free_at = i;
					end
				end
				if (free_at >= 0) begin
					tab_major[free_at] = w.major;
					tab_minor[free_at] = w.minor;
					tab_rssi[free_at] = w.rssi;
					tab_extra[free_at] = w.extra;
					tab_seen[free_at] = w.now_secs;
					r = blank(ST_ADDED);
					r.slot = 5'(free_at);
					expected_words.push_back(r);
				end else begin
					expected_words.push_back(blank(ST_FULL));
				end
			end
			K_COUNT: begin
				cnt = 0;
				for (int i = 0; i < n; i++)
					if (tab_seen[i] != 0 && (w.window_secs == 0 ||
					    32'(w.now_secs - tab_seen[i]) < w.window_secs))
						cnt++;
				r = blank(ST_COUNT);
				r.count = 6'(cnt);
				expected_words.push_back(r);
			end
			K_AGE: begin
				for (int i = 0; i < n; i++)
					if (tab_seen[i] != 0 && (w.window_secs == 0 ||
					    32'(w.now_secs - tab_seen[i]) > w.window_secs))
						tab_seen[i] = '0;
				expected_words.push_back(blank(ST_AGED));
			end
			default: begin
				k = 0;
				lim = (w.max_count > MAX_OUT) ? MAX_OUT : w.max_count;
				for (lvl = -1; lvl >= -128 && k < lim; lvl--)
					for (int i = 0; i < n && k < lim; i++)
						if (tab_seen[i] != 0 && $signed(tab_rssi[i]) == lvl) begin
							r = '0;
							r.status = ST_ITEM;
							r.out_major = tab_major[i];
							r.out_minor = tab_minor[i];
							r.out_rssi = tab_rssi[i];
							r.out_extra = tab_extra[i];
							expected_words.push_back(r);
							k++;
						end
				if (k == 0) expected_words.push_back(blank(ST_NONE));
				else expected_words[$].last = 1'b1;
			end
		endcase
	endtask

	// sender: offers queued words, predicts on acceptance
	always @(posedge clk) begin
		if (req_valid && req_ready) predict_table_op(req);
		if (!req_valid || req_ready) begin
			if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				req <= pending_words.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// receiver: checks each accepted word against the oldest expectation
	always @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			if (expected_words.size() == 0) begin
				report($sformatf("unexpected word %p", rsp));
			end else begin
				rsp_t e;
				e = expected_words.pop_front();
				if (rsp.status !== e.status) report($sformatf("status %0d exp %0d", rsp.status, e.status));
				if (rsp.slot !== e.slot) report($sformatf("slot %0d exp %0d", rsp.slot, e.slot));
				if (rsp.count !== e.count) report($sformatf("count %0d exp %0d", rsp.count, e.count));
				if (rsp.out_major !== e.out_major) report($sformatf("major %h exp %h", rsp.out_major, e.out_major));
				if (rsp.out_minor !== e.out_minor) report($sformatf("minor %h exp %h", rsp.out_minor, e.out_minor));
				if (rsp.out_rssi !== e.out_rssi) report($sformatf("rssi %0d exp %0d", rsp.out_rssi, e.out_rssi));
				if (rsp.out_extra !== e.out_extra) report($sformatf("extra %h exp %h", rsp.out_extra, e.out_extra));
				if (rsp.last !== e.last) report($sformatf("last %0b exp %0b", rsp.last, e.last));
			end
		end
		rsp_ready <= (hold_off == 0) && ($urandom_range(99) >= recv_idle_pct);
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_off > 0) hold_off <= hold_off - 1;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 64'd2000000) begin
			$display("beacon_sighting_table_top test failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MAJOR_LOW:  lim_low = val;
			REG_MAJOR_HIGH: lim_high = val;
			default:        size_reg = val[5:0];
		endcase
	endtask

	task automatic drain();
		while (pending_words.size() > 0 || req_valid || expected_words.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic req_t make_word(input logic [1:0] kind, input logic [31:0] now,
		input logic [15:0] maj, input logic [15:0] mnr, input logic [7:0] rs,
		input logic [31:0] win, input logic [5:0] mc);
		req_t w;
		w.kind = kind;
		w.now_secs = now;
		w.major = maj;
		w.minor = mnr;
		w.rssi = rs;
		w.extra = 8'($urandom);
		w.window_secs = win;
		w.max_count = mc;
		return w;
	endfunction

	// random word: mostly observes on a small id set so updates and sorts have matter
	function automatic req_t rand_word(input logic [31:0] now);
		req_t w;
		int   p;
		p = $urandom_range(99);
		w = make_word(K_OBSERVE, now, 16'($urandom_range(0, 12)), 16'($urandom_range(0, 6)),
			8'($urandom), 32'($urandom_range(0, 60)), 6'($urandom_range(0, 40)));
		if ($urandom_range(9) == 0) begin
			w.major = 16'($urandom);
			w.minor = 16'($urandom);
			w.now_secs = $urandom;
			w.window_secs = $urandom;
			w.max_count = 6'($urandom);
		end
		if ($urandom_range(3) == 0) w.window_secs = 0;
		if (p < 55) w.kind = K_OBSERVE;
		else if (p < 70) w.kind = K_COUNT;
		else if (p < 80) w.kind = K_AGE;
		else w.kind = K_SORT;
		return w;
	endfunction

	initial begin
		logic [31:0] now;
		errors = 0;
		cycles = 0;
		hold_off = 0;
		send_idle_pct = 26;
		recv_idle_pct = 85;
		lim_low = 0;
		lim_high = 0;
		size_reg = 0;
		for (int i = 0; i < TABLE_DEPTH; i++) tab_seen[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed: size zero, then full range and full depth
		pending_words.push_back(make_word(K_OBSERVE, 5, 0, 0, 8'h80, 0, 0));
		pending_words.push_back(make_word(K_SORT, 5, 0, 0, 0, 0, 32));
		drain();
		write_reg(REG_MAJOR_LOW, 16'h0000);
		write_reg(REG_MAJOR_HIGH, 16'hffff);
		write_reg(REG_TABLE_SIZE, 16'd63);
		pending_words.push_back(make_word(K_OBSERVE, 0, 1, 1, 8'hff, 0, 0));
		pending_words.push_back(make_word(K_OBSERVE, 32'hffffffff, 16'hffff, 16'hffff,
			8'h80, 0, 0));
		pending_words.push_back(make_word(K_OBSERVE, 10, 0, 0, 8'h7f, 0, 0));
		pending_words.push_back(make_word(K_OBSERVE, 11, 2, 2, 8'hff, 0, 0));
		pending_words.push_back(make_word(K_OBSERVE, 12, 0, 0, 8'hfe, 0, 0));
		pending_words.push_back(make_word(K_COUNT, 20, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(K_COUNT, 20, 0, 0, 0, 9, 0));
		pending_words.push_back(make_word(K_COUNT, 20, 0, 0, 0, 32'hffffffff, 0));
		pending_words.push_back(make_word(K_SORT, 20, 0, 0, 0, 0, 63));
		pending_words.push_back(make_word(K_SORT, 20, 0, 0, 0, 0, 1));
		pending_words.push_back(make_word(K_SORT, 20, 0, 0, 0, 0, 0));
		pending_words.push_back(make_word(K_AGE, 20, 0, 0, 0, 8, 0));
		pending_words.push_back(make_word(K_AGE, 20, 0, 0, 0, 0, 0));
		for (int i = 0; i < 33; i++)
			pending_words.push_back(make_word(K_OBSERVE, 100 + i, 16'(i), 7, 8'($urandom),
				0, 0));
		pending_words.push_back(make_word(K_SORT, 200, 0, 0, 0, 0, 32));
		pending_words.push_back(make_word(K_AGE, 200, 0, 0, 0, 0, 0));
		drain();
		// filtering, including an empty range
		write_reg(REG_MAJOR_LOW, 16'd5);
		write_reg(REG_MAJOR_HIGH, 16'd4);
		write_reg(REG_TABLE_SIZE, 16'd1);
		pending_words.push_back(make_word(K_OBSERVE, 1, 5, 0, 8'hf0, 0, 0));
		pending_words.push_back(make_word(K_OBSERVE, 1, 4, 0, 8'hf0, 0, 0));
		drain();

		// random phases over several settings
		now = 1000;
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin
				send_idle_pct = 85;
				recv_idle_pct = 26;
			end
			if (ph == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_reg(REG_MAJOR_LOW, 16'($urandom_range(0, 3)));
			write_reg(REG_MAJOR_HIGH, (ph == 5) ? 16'hffff : 16'($urandom_range(6, 12)));
			write_reg(REG_TABLE_SIZE, 16'($urandom_range(1, 40)));
			for (int i = 0; i < 35; i++) begin
				now = now + $urandom_range(0, 20);
				pending_words.push_back(rand_word(now));
			end
			if (ph == 1) begin
				hold_off = 600;
				for (int i = 0; i < 10; i++)
					pending_words.push_back(make_word(K_SORT, now, 0, 0, 0, 0, 32));
			end
			drain();
		end

		if (errors == 0) begin
			$display("beacon_sighting_table_top test passed");
		end else begin
			$display("beacon_sighting_table_top test failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
